FILE: rtl/core/mipd_pkg.sv
// Package for the minimum-image pair distance block: widths, register
// indexes and the record types that travel between its modules.
// Depends on nothing; every other file of the block refers to it.
`timescale 1ns / 1ps
`default_nettype none

package mipd_pkg;

  // Coordinate format: signed Q16.16
  localparam int CoordBits   = 32;
  localparam int FracBits    = 16;
  localparam int LenBits     = 31;
  localparam int InvBits     = 32;

  // Wrap datapath widths
  localparam int DiffBits    = CoordBits + 1;
  localparam int ProdBits    = DiffBits + InvBits;
  localparam int RoundShift  = FracBits + 32;
  localparam int QuotBits    = ProdBits - RoundShift + 1;
  localparam int NlBits      = QuotBits + LenBits;
  localparam int WideBits    = NlBits + 2;

  // Squared distance and root
  localparam int SqBits      = 2 * CoordBits - 1;
  localparam int SumBits     = 2 * CoordBits;
  localparam int ResBits     = 2 * CoordBits;
  localparam int RootBits    = 32;
  localparam int SqrtSteps   = RootBits;

  // Stages ahead of the square-root chain: seven per axis plus the sum
  localparam int FrontStages = 8;

  // Configuration port
  localparam int CfgAddrBits = 3;
  localparam int CfgDataBits = 32;

  localparam logic [LenBits-1:0] LenReset = LenBits'(65536);
  localparam logic [InvBits-1:0] InvReset = '1;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [CfgAddrBits-1:0] {
    CFG_BOX_LEN_X = 3'd0,
    CFG_BOX_LEN_Y = 3'd1,
    CFG_BOX_LEN_Z = 3'd2,
    CFG_INV_LEN_X = 3'd3,
    CFG_INV_LEN_Y = 3'd4,
    CFG_INV_LEN_Z = 3'd5
  } cfg_idx_t;

  // One pair of points
  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
  } pair_t;

  // Record handed from one square-root cell to the next
  typedef struct packed {
    logic [SqBits-1:0]  rem;
    logic [ResBits-1:0] res;
    logic [SqBits-1:0]  dist_sq;
    coord_t             disp_x;
    coord_t             disp_y;
    coord_t             disp_z;
  } sqrt_lane_t;

endpackage

`default_nettype wire

FILE: rtl/core/mipd_if.sv
// Valid/ready channel interfaces of the minimum-image pair distance block.
// Depends on mipd_pkg for the coordinate type.
`timescale 1ns / 1ps
`default_nettype none

interface mipd_in_if;
  logic            valid;
  logic            ready;
  mipd_pkg::coord_t a_x;
  mipd_pkg::coord_t a_y;
  mipd_pkg::coord_t a_z;
  mipd_pkg::coord_t b_x;
  mipd_pkg::coord_t b_y;
  mipd_pkg::coord_t b_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface mipd_out_if;
  logic                               valid;
  logic                               ready;
  mipd_pkg::coord_t                   disp_x;
  mipd_pkg::coord_t                   disp_y;
  mipd_pkg::coord_t                   disp_z;
  logic [mipd_pkg::SqBits-1:0]        dist_sq;
  logic [mipd_pkg::RootBits-1:0]      dist_res;

  modport source (output valid, disp_x, disp_y, disp_z, dist_sq, dist_res, input ready);
  modport sink   (input valid, disp_x, disp_y, disp_z, dist_sq, dist_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mipd_axis_wrap.sv
// One axis of the minimum-image front end: difference, nearest-integer
// wrap by the reciprocal box length, saturation and square. Seven stages.
// Depends on mipd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mipd_axis_wrap (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire mipd_pkg::coord_t              a,
  input  wire mipd_pkg::coord_t              b,
  input  wire logic [mipd_pkg::LenBits-1:0]  len,
  input  wire logic [mipd_pkg::InvBits-1:0]  inv,
  output      mipd_pkg::coord_t              w,
  output      logic [mipd_pkg::SqBits-1:0]   sq
);

  localparam int DB = mipd_pkg::DiffBits;
  localparam int PB = mipd_pkg::ProdBits;
  localparam int RS = mipd_pkg::RoundShift;
  localparam int QB = mipd_pkg::QuotBits;
  localparam int NB = mipd_pkg::NlBits;
  localparam int WB = mipd_pkg::WideBits;
  localparam int CB = mipd_pkg::CoordBits;

  // stage 1
  logic signed [DB-1:0] d1_r, d1_nxt;
  // stage 2
  logic signed [DB-1:0] d2_r;
  logic [DB-1:0]        m2_r, m2_nxt;
  // stage 3
  logic signed [DB-1:0] d3_r;
  logic [PB-1:0]        p3_r, p3_nxt;
  // stage 4
  logic signed [DB-1:0] d4_r;
  logic [QB-1:0]        k4_r, k4_nxt;
  // stage 5
  logic signed [DB-1:0] d5_r;
  logic [NB-1:0]        nl5_r, nl5_nxt;
  // stage 6
  mipd_pkg::coord_t     w6_r, w6_nxt;
  // stage 7
  mipd_pkg::coord_t     w7_r;
  logic [mipd_pkg::SqBits-1:0] sq7_r, sq7_nxt;

  logic [RS-1:0]            frac;
  logic [QB-1:0]            quot;
  logic                     round_up;
  logic signed [WB-1:0]     wide;
  logic                     ovf;
  logic signed [2*CB-1:0]   sq_full;

  // difference, magnitude, product with the reciprocal
  always_comb begin
    d1_nxt = {a[CB-1], a} - {b[CB-1], b};
    m2_nxt = d1_r[DB-1] ? DB'(-d1_r) : DB'(d1_r);
    p3_nxt = PB'(m2_r) * PB'(inv);
  end

  // round to nearest, ties to even
  always_comb begin
    frac     = p3_r[RS-1:0];
    quot     = QB'(p3_r[PB-1:RS]);
    round_up = frac[RS-1] && ((frac[RS-2:0] != '0) || quot[0]);
    k4_nxt   = quot + QB'(round_up);
  end

  // multiple of the box length, subtract and saturate, then square
  always_comb begin
    nl5_nxt = NB'(k4_r) * NB'(len);
    if (d5_r[DB-1]) begin
      wide = WB'(d5_r) + WB'(nl5_r);
    end else begin
      wide = WB'(d5_r) - WB'(nl5_r);
    end
    ovf = (wide[WB-1:CB-1] != {(WB-CB+1){wide[WB-1]}});
    if (ovf) begin
      w6_nxt = wide[WB-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    end else begin
      w6_nxt = wide[CB-1:0];
    end
    sq_full = w6_r * w6_r;
    sq7_nxt = sq_full[mipd_pkg::SqBits-1:0];
  end

  // advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r  <= d1_nxt;
      d2_r  <= d1_r;
      m2_r  <= m2_nxt;
      d3_r  <= d2_r;
      p3_r  <= p3_nxt;
      d4_r  <= d3_r;
      k4_r  <= k4_nxt;
      d5_r  <= d4_r;
      nl5_r <= nl5_nxt;
      w6_r  <= w6_nxt;
      w7_r  <= w6_r;
      sq7_r <= sq7_nxt;
    end
  end

  assign w  = w7_r;
  assign sq = sq7_r;

endmodule

`default_nettype wire

FILE: rtl/core/mipd_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit and hands the
// remainder, partial root and the result payload on to the next cell.
// Depends on mipd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mipd_sqrt_cell #(
  parameter int BIT_POS = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_i,
  input  wire mipd_pkg::sqrt_lane_t lane_i,
  output      logic                 vld_o,
  output      mipd_pkg::sqrt_lane_t lane_o
);

  localparam int RB = mipd_pkg::ResBits;
  localparam int SB = mipd_pkg::SqBits;
  localparam logic [RB-1:0] TrialBit = RB'(1) << (2 * BIT_POS);

  logic                 vld_r;
  mipd_pkg::sqrt_lane_t lane_r, lane_nxt;
  logic [RB-1:0]        trial;
  logic                 take;

  // subtract the trial value when it fits
  always_comb begin
    trial    = lane_i.res + TrialBit;
    take     = {1'b0, lane_i.rem} >= trial;
    lane_nxt = lane_i;
    if (take) begin
      lane_nxt.rem = lane_i.rem - trial[SB-1:0];
      lane_nxt.res = (lane_i.res >> 1) + TrialBit;
    end else begin
      lane_nxt.res = lane_i.res >> 1;
    end
  end

  // hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign lane_o = lane_r;

endmodule

`default_nettype wire

FILE: rtl/core/min_image_pair_distance.sv
// Top level of the minimum-image pair distance block.
// Depends on mipd_pkg, mipd_if, mipd_axis_wrap and mipd_sqrt_cell.
//
// Takes one pair of Q16.16 points per cycle unless the output stalls and returns
// the wrapped displacement, squared distance (Q31.32, saturated) and floor root
// (Q16.16). Seven stages per axis for difference, reciprocal product, rounding,
// box multiple, saturation and square, one stage for the sum, then a chain of
// 32 square-root cells that each settle one root bit. The whole pipe advances
// when the output register is empty or taken; a one-entry skid stage at the
// input takes one more transaction while the output is held. The user must
// write box lengths and reciprocals only while idle; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module min_image_pair_distance (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  mipd_in_if.sink                               in_ch,
  mipd_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [mipd_pkg::CfgAddrBits-1:0] cfg_addr,
  input  wire logic [mipd_pkg::CfgDataBits-1:0] cfg_wdata
);

  localparam int NS = mipd_pkg::SqrtSteps;
  localparam int FS = mipd_pkg::FrontStages;

  // configuration registers
  logic [mipd_pkg::LenBits-1:0] box_len_r [3];
  logic [mipd_pkg::InvBits-1:0] inv_len_r [3];

  // input skid stage
  logic            skid_v_r, skid_v_nxt;
  mipd_pkg::pair_t skid_r, in_item, head;
  logic            in_fire, head_v, en, out_vld;

  logic [FS-1:0]   front_v_r;

  mipd_pkg::coord_t            w_x, w_y, w_z;
  logic [mipd_pkg::SqBits-1:0] sq_x, sq_y, sq_z;
  logic [mipd_pkg::SumBits-1:0] sum;
  logic [mipd_pkg::SqBits-1:0] dsq_r, dsq_nxt;
  mipd_pkg::coord_t            dx_r, dy_r, dz_r;

  logic                 cell_v    [NS+1];
  mipd_pkg::sqrt_lane_t cell_lane [NS+1];

  // write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        box_len_r[i] <= mipd_pkg::LenReset;
        inv_len_r[i] <= mipd_pkg::InvReset;
      end
    end else if (cfg_we) begin
      unique case (mipd_pkg::cfg_idx_t'(cfg_addr))
        mipd_pkg::CFG_BOX_LEN_X: box_len_r[0] <= cfg_wdata[mipd_pkg::LenBits-1:0];
        mipd_pkg::CFG_BOX_LEN_Y: box_len_r[1] <= cfg_wdata[mipd_pkg::LenBits-1:0];
        mipd_pkg::CFG_BOX_LEN_Z: box_len_r[2] <= cfg_wdata[mipd_pkg::LenBits-1:0];
        mipd_pkg::CFG_INV_LEN_X: inv_len_r[0] <= cfg_wdata[mipd_pkg::InvBits-1:0];
        mipd_pkg::CFG_INV_LEN_Y: inv_len_r[1] <= cfg_wdata[mipd_pkg::InvBits-1:0];
        mipd_pkg::CFG_INV_LEN_Z: inv_len_r[2] <= cfg_wdata[mipd_pkg::InvBits-1:0];
        default: ;
      endcase
    end
  end

  // pick the head transaction: skid first, else the port
  always_comb begin
    in_item.a_x = in_ch.a_x;
    in_item.a_y = in_ch.a_y;
    in_item.a_z = in_ch.a_z;
    in_item.b_x = in_ch.b_x;
    in_item.b_y = in_ch.b_y;
    in_item.b_z = in_ch.b_z;
    out_vld     = cell_v[NS];
    en          = !out_vld || out_ch.ready;
    in_fire     = in_ch.valid && !skid_v_r;
    head        = skid_v_r ? skid_r : in_item;
    head_v      = skid_v_r || in_fire;
    skid_v_nxt  = en ? 1'b0 : (skid_v_r || in_fire);
  end

  assign in_ch.ready = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  // park a transaction while the pipe is held
  always_ff @(posedge clk) begin
    if (!en && !skid_v_r) begin
      skid_r <= in_item;
    end
  end

  // front stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= '0;
    end else if (en) begin
      front_v_r <= {front_v_r[FS-2:0], head_v};
    end
  end

  mipd_axis_wrap u_axis_x (
    .clk (clk), .en (en), .a (head.a_x), .b (head.b_x),
    .len (box_len_r[0]), .inv (inv_len_r[0]), .w (w_x), .sq (sq_x)
  );

  mipd_axis_wrap u_axis_y (
    .clk (clk), .en (en), .a (head.a_y), .b (head.b_y),
    .len (box_len_r[1]), .inv (inv_len_r[1]), .w (w_y), .sq (sq_y)
  );

  mipd_axis_wrap u_axis_z (
    .clk (clk), .en (en), .a (head.a_z), .b (head.b_z),
    .len (box_len_r[2]), .inv (inv_len_r[2]), .w (w_z), .sq (sq_z)
  );

  // sum the squares and saturate to 63 bits
  always_comb begin
    sum = mipd_pkg::SumBits'(sq_x) + mipd_pkg::SumBits'(sq_y)
        + mipd_pkg::SumBits'(sq_z);
    dsq_nxt = sum[mipd_pkg::SumBits-1] ? '1 : sum[mipd_pkg::SqBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsq_r <= dsq_nxt;
      dx_r  <= w_x;
      dy_r  <= w_y;
      dz_r  <= w_z;
    end
  end

  // feed the square-root chain
  always_comb begin
    cell_v[0]            = front_v_r[FS-1];
    cell_lane[0].rem     = dsq_r;
    cell_lane[0].res     = '0;
    cell_lane[0].dist_sq = dsq_r;
    cell_lane[0].disp_x  = dx_r;
    cell_lane[0].disp_y  = dy_r;
    cell_lane[0].disp_z  = dz_r;
  end

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    mipd_sqrt_cell #(
      .BIT_POS (NS - 1 - i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (cell_v[i]),
      .lane_i (cell_lane[i]),
      .vld_o  (cell_v[i+1]),
      .lane_o (cell_lane[i+1])
    );
  end

  // drive the result channel from the last cell
  assign out_ch.valid    = out_vld;
  assign out_ch.disp_x   = cell_lane[NS].disp_x;
  assign out_ch.disp_y   = cell_lane[NS].disp_y;
  assign out_ch.disp_z   = cell_lane[NS].disp_z;
  assign out_ch.dist_sq  = cell_lane[NS].dist_sq;
  assign out_ch.dist_res = cell_lane[NS].res[mipd_pkg::RootBits-1:0];

  // root bounds for checking
  logic [2*mipd_pkg::RootBits+1:0] root_sq, root1_sq;

  always_comb begin
    root_sq  = (2*mipd_pkg::RootBits+2)'(out_ch.dist_res)
             * (2*mipd_pkg::RootBits+2)'(out_ch.dist_res);
    root1_sq = ((2*mipd_pkg::RootBits+2)'(out_ch.dist_res) + 1'b1)
             * ((2*mipd_pkg::RootBits+2)'(out_ch.dist_res) + 1'b1);
  end

  a_root_floor : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (root_sq <= (2*mipd_pkg::RootBits+2)'(out_ch.dist_sq))
                  && (root1_sq > (2*mipd_pkg::RootBits+2)'(out_ch.dist_sq)))
    else $error("dist_res is not the floor root of dist_sq");

  a_front_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(front_v_r))
    else $error("front stages moved while the output was held");

  a_skid_fill : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> ($past(en) == 1'b0))
    else $error("skid stage filled while the pipe was advancing");

endmodule

`default_nettype wire

FILE: sim/min_image_pair_distance_tb.sv
// Self-checking testbench for min_image_pair_distance: minimum-image wrap,
// squared distance and floor root, checked against a predictor kept here.
// Depends on mipd_pkg, the mipd_if channel interfaces and the RTL top level.
`timescale 1ns / 1ps

module min_image_pair_distance_tb;
  import mipd_pkg::*;

  localparam coord_t CoordHi = 32'sh7FFF_FFFF;
  localparam coord_t CoordLo = 32'sh8000_0000;
  localparam coord_t QOne = 32'sh0001_0000;
  localparam logic [RoundShift-1:0] HalfStep = 1'b1 << (RoundShift - 1);
  localparam logic [CfgAddrBits-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgAddrBits-1:0] CfgSpareB = 3'd7;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 60;

  typedef struct packed {
    coord_t               disp_x;
    coord_t               disp_y;
    coord_t               disp_z;
    logic [SqBits-1:0]    dist_sq;
    logic [RootBits-1:0]  dist_res;
  } dist_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgAddrBits-1:0] cfg_addr;
  logic [CfgDataBits-1:0] cfg_wdata;

  mipd_in_if  in_ch ();
  mipd_out_if out_ch ();

  // Shadow copy of the box registers
  logic [LenBits-1:0] box_len_cfg [3];
  logic [InvBits-1:0] inv_len_cfg [3];

  dist_result_t pending_distances [$];
  int error_count;
  int quiet_cycles;
  int src_idle_pct;
  int snk_stall_pct;

  min_image_pair_distance uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Wrap one axis: subtract the nearest box multiple, ties to even, then saturate
  function automatic coord_t min_image_wrap(longint d, logic [LenBits-1:0] len,
                                            logic [InvBits-1:0] inv);
    logic neg;
    logic [63:0] mag;
    logic [63:0] quot;
    logic [RoundShift-1:0] frac;
    logic [127:0] prod;
    logic [127:0] nl;
    longint w;
    neg = (d < 0);
    mag = neg ? 64'(-d) : 64'(d);
    prod = 128'(mag) * 128'(inv);
    quot = prod[RoundShift +: 64];
    frac = prod[RoundShift-1:0];
    if (frac > HalfStep || (frac == HalfStep && quot[0])) quot = quot + 1;
    nl = 128'(quot) * 128'(len);
    // box multiple far out of range: pin to the opposite rail
    if (nl >= (128'd1 << 62)) return neg ? CoordHi : CoordLo;
    w = neg ? d + longint'(nl[63:0]) : d - longint'(nl[63:0]);
    if (w > longint'(CoordHi)) w = longint'(CoordHi);
    if (w < longint'(CoordLo)) w = longint'(CoordLo);
    return coord_t'(w);
  endfunction

  // Bitwise floor square root, two bits of radicand per step
  function automatic logic [RootBits-1:0] floor_sqrt(logic [SqBits-1:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem = 64'(v);
    root = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[RootBits-1:0];
  endfunction

  function automatic dist_result_t predict_pair_distance(pair_t p);
    dist_result_t r;
    coord_t pa [3];
    coord_t pb [3];
    coord_t w [3];
    logic [63:0] mag;
    logic [65:0] acc;
    logic [SqBits-1:0] sq;
    int i;
    pa[0] = p.a_x; pa[1] = p.a_y; pa[2] = p.a_z;
    pb[0] = p.b_x; pb[1] = p.b_y; pb[2] = p.b_z;
    acc = '0;
    for (i = 0; i < 3; i++) begin
      w[i] = min_image_wrap(longint'(pa[i]) - longint'(pb[i]), box_len_cfg[i], inv_len_cfg[i]);
      mag = (w[i] < 0) ? 64'(-longint'(w[i])) : 64'(longint'(w[i]));
      acc = acc + 66'(mag) * 66'(mag);
    end
    // saturate the squared sum to 63 bits
    sq = (acc > 66'h7FFF_FFFF_FFFF_FFFF) ? '1 : acc[SqBits-1:0];
    r.disp_x = w[0];
    r.disp_y = w[1];
    r.disp_z = w[2];
    r.dist_sq = sq;
    r.dist_res = floor_sqrt(sq);
    return r;
  endfunction

  // Q0.32 reciprocal of a Q16.16 length, clipped to 32 bits
  function automatic logic [InvBits-1:0] recip_q32(logic [LenBits-1:0] len);
    logic [63:0] q;
    if (len == 0) return '1;
    q = (64'd1 << RoundShift) / 64'(len);
    return (q > 64'hFFFF_FFFF) ? '1 : q[InvBits-1:0];
  endfunction

  function automatic pair_t make_pair(coord_t ax, coord_t ay, coord_t az,
                                      coord_t bx, coord_t by, coord_t bz);
    pair_t p;
    p.a_x = ax; p.a_y = ay; p.a_z = az;
    p.b_x = bx; p.b_y = by; p.b_z = bz;
    return p;
  endfunction

  // Mix of full-range points, corner values and offsets of a few box lengths
  function automatic pair_t random_pair();
    coord_t a [3];
    coord_t b [3];
    coord_t corners [7];
    longint span;
    longint off;
    int unsigned pick;
    int i;
    corners = '{CoordHi, CoordLo, 0, -1, 1, QOne, -QOne};
    for (i = 0; i < 3; i++) begin
      pick = $urandom_range(99);
      b[i] = $urandom;
      span = (box_len_cfg[i] == 0) ? longint'(QOne) : longint'(box_len_cfg[i]);
      if (pick < 30) begin
        a[i] = $urandom;
      end else if (pick < 45) begin
        a[i] = corners[$urandom_range(6)];
        b[i] = corners[$urandom_range(6)];
      end else if (pick < 60) begin
        // odd multiple of half a box: a rounding tie when the reciprocal is exact
        off = (longint'($urandom_range(8)) - 4) * span + span / 2;
        a[i] = coord_t'(longint'(b[i]) + off);
      end else begin
        off = (longint'($urandom_range(8)) - 4) * span
              + longint'($urandom_range(32'(span))) - span / 2;
        a[i] = coord_t'(longint'(b[i]) + off);
      end
    end
    return make_pair(a[0], a[1], a[2], b[0], b[1], b[2]);
  endfunction

  // Offer one pair and hold it until the transaction completes
  task automatic send_pair(input pair_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_x <= p.a_x;
    in_ch.a_y <= p.a_y;
    in_ch.a_z <= p.a_z;
    in_ch.b_x <= p.b_x;
    in_ch.b_y <= p.b_y;
    in_ch.b_z <= p.b_z;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BOX_LEN_X, CFG_BOX_LEN_Y, CFG_BOX_LEN_Z: begin
        box_len_cfg[idx] = data[LenBits-1:0];
      end
      CFG_INV_LEN_X, CFG_INV_LEN_Y, CFG_INV_LEN_Z: begin
        inv_len_cfg[idx - CFG_INV_LEN_X] = data;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_box(input logic [CfgDataBits-1:0] len_x, len_y, len_z,
                          input logic [CfgDataBits-1:0] inv_x, inv_y, inv_z);
    wait_idle();
    write_reg(CFG_BOX_LEN_X, len_x);
    write_reg(CFG_BOX_LEN_Y, len_y);
    write_reg(CFG_BOX_LEN_Z, len_z);
    write_reg(CFG_INV_LEN_X, inv_x);
    write_reg(CFG_INV_LEN_Y, inv_y);
    write_reg(CFG_INV_LEN_Z, inv_z);
  endtask

  // Random box per axis; mostly matching reciprocals, some deliberately off
  task automatic load_random_box();
    logic [CfgDataBits-1:0] lens [3];
    logic [CfgDataBits-1:0] invs [3];
    int unsigned pick;
    int i;
    for (i = 0; i < 3; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) lens[i] = $urandom_range(32'h0040_0000, 32'h0001_0000);
      else if (pick < 75) lens[i] = $urandom_range(32'h7FFF_FFFF, 32'h0001_0000);
      else lens[i] = 32'd1 << $urandom_range(30, 17);
      invs[i] = ($urandom_range(99) < 20) ? $urandom : recip_q32(lens[i][LenBits-1:0]);
      lens[i][CfgDataBits-1] = $urandom_range(1);
    end
    load_box(lens[0], lens[1], lens[2], invs[0], invs[1], invs[2]);
  endtask

  task automatic check_field(input string what, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
      error_count++;
    end
  endtask

  // Unit box at reset: corners and points near the half-box boundary
  task automatic test_reset_defaults();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    send_pair(make_pair(0, 0, 0, 0, 0, 0));
    send_pair(make_pair(CoordHi, CoordHi, CoordHi, CoordLo, CoordLo, CoordLo));
    send_pair(make_pair(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi));
    send_pair(make_pair(QOne / 2, -QOne / 2, 3 * QOne / 4, 0, 0, 0));
    send_pair(make_pair(5 * QOne / 2, -7 * QOne / 2, 1, 0, 0, 0));
    send_pair(make_pair(CoordHi, CoordLo, -1, CoordHi, CoordLo, 1));
  endtask

  // Box of 2.0 with an exact reciprocal: odd multiples of 1.0 are ties
  task automatic test_half_ties();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    load_box(32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pair(make_pair(QOne, -QOne, 3 * QOne, 0, 0, 0));
    send_pair(make_pair(5 * QOne, -3 * QOne, 7 * QOne, 0, 0, 0));
    send_pair(make_pair(2 * QOne, QOne, -5 * QOne, QOne, 2 * QOne, 0));
  endtask

  // Zero reciprocals and a zero length leave differences unwrapped, so large ones
  // and squared sums saturate; bit 31 of a length and spare indexes are ignored
  task automatic test_unwrapped_saturation();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    load_box(32'h8000_0000, 32'hFFFF_FFFF, 32'h8001_0000, '0, '0, '0);
    write_reg(CfgSpareA, 32'h0000_0001);
    write_reg(CfgSpareB, 32'h0000_0001);
    send_pair(make_pair(CoordHi, CoordHi, CoordHi, CoordLo, CoordLo, CoordLo));
    send_pair(make_pair(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi));
    send_pair(make_pair(CoordHi, 0, 0, CoordLo, 0, 0));
    send_pair(make_pair(1, 1, 1, 0, 0, 0));
  endtask

  // Largest and smallest box lengths, and a power-of-two box with a tie
  task automatic test_extreme_boxes();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    load_box(32'h7FFF_FFFF, 32'h0001_0000, 32'h4000_0000,
             recip_q32(31'h7FFF_FFFF), 32'hFFFF_FFFF, 32'h0004_0000);
    send_pair(make_pair(CoordHi, CoordHi, CoordHi, CoordLo, CoordLo, CoordLo));
    send_pair(make_pair(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi));
    send_pair(make_pair(32'sh4000_0000, QOne / 2, 32'sh2000_0000,
                        -32'sh4000_0000, 0, -32'sh2000_0000));
    send_pair(make_pair(-1, 1, 32'sh6000_0000, 0, 0, 0));
  endtask

  // Random pairs over random boxes, through each idling pattern
  task automatic test_random_traffic();
    int src_pcts [4];
    int snk_pcts [4];
    int phase;
    int rep;
    src_pcts = '{0, 71, 0, 33};
    snk_pcts = '{0, 0, 71, 33};
    for (phase = 0; phase < 4; phase++) begin
      for (rep = 0; rep < 2; rep++) begin
        load_random_box();
        src_idle_pct = src_pcts[phase];
        snk_stall_pct = snk_pcts[phase];
        repeat (95) send_pair(random_pair());
      end
    end
  endtask

  // Randomly stall the result channel
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Predict on each accepted pair, compare each accepted result
  always @(posedge clk) begin
    dist_result_t want;
    logic in_fire;
    logic out_fire;
    if (rst_n) begin
      in_fire = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      if (in_fire) begin
        pending_distances.push_back(predict_pair_distance(make_pair(
          in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z)));
      end
      if (out_fire) begin
        if (pending_distances.size() == 0) begin
          $display("%0t: unexpected result, disp %h %h %h dist_sq %h dist_res %h", $time,
                   out_ch.disp_x, out_ch.disp_y, out_ch.disp_z, out_ch.dist_sq,
                   out_ch.dist_res);
          error_count++;
        end else begin
          want = pending_distances.pop_front();
          check_field("disp_x", want.disp_x, out_ch.disp_x);
          check_field("disp_y", want.disp_y, out_ch.disp_y);
          check_field("disp_z", want.disp_z, out_ch.disp_z);
          check_field("dist_sq", want.dist_sq, out_ch.dist_sq);
          check_field("dist_res", want.dist_res, out_ch.dist_res);
        end
      end
      quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
    end
  end

  // Abort when no transaction moves for too long
  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, StallLimit);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.a_x = '0;
    in_ch.a_y = '0;
    in_ch.a_z = '0;
    in_ch.b_x = '0;
    in_ch.b_y = '0;
    in_ch.b_z = '0;
    out_ch.ready = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    for (i = 0; i < 3; i++) begin
      box_len_cfg[i] = LenReset;
      inv_len_cfg[i] = InvReset;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_half_ties();
    test_unwrapped_saturation();
    test_extreme_boxes();
    test_random_traffic();

    // Let the pipe empty, then watch for stray results
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
